// ===== design/line_position_pid_steer_top_defines.svh =====
// Assertion macros shared by the steering block.
// Both macros clock on clk and stay quiet while arst_n is low.
`ifndef LINE_POSITION_PID_STEER_TOP_DEFINES_SVH
`define LINE_POSITION_PID_STEER_TOP_DEFINES_SVH

// Same-cycle implication.
`define LPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lps_pkg.sv =====
package lps_pkg;

	localparam int SENSORS     = 7;
	localparam int SAMPLE_BITS = 12;
	localparam int POS_STEP    = 100;

	localparam int CNT_W   = 4;
	localparam int SUM_W   = 13;
	localparam int POS_W   = 10;
	localparam int ERR_W   = 11;
	localparam int DIFF_W  = 12;
	localparam int DUTY_W  = 8;
	localparam int GAIN_W  = 8;
	localparam int CORR_W  = 18;

	// Shared multiplier geometry
	localparam int MUL_AW    = 22;
	localparam int MUL_BW    = 23;
	localparam int PROD_W    = MUL_AW + MUL_BW;
	localparam int RECIP_W   = 19;
	localparam int POS_SHIFT = 18;
	localparam int DIV_SHIFT = 29;
	localparam int Q_W       = 16;
	// ceil(2^29 / 100): exact floor divide for products below 2^22
	localparam logic [MUL_BW-1:0] DIV100_RECIP = 23'd5368710;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DARK_THRESHOLD  = 3'd0,
		REG_CENTER_POSITION = 3'd1,
		REG_GAIN_P          = 3'd2,
		REG_GAIN_I          = 3'd3,
		REG_GAIN_D          = 3'd4,
		REG_BASE_LEFT       = 3'd5,
		REG_BASE_RIGHT      = 3'd6,
		REG_DUTY_CEILING    = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS,
		ST_ERR,
		ST_P_MUL,
		ST_P_DIV,
		ST_I_MUL,
		ST_I_DIV,
		ST_D_MUL,
		ST_D_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] dark_threshold;
		logic [POS_W-1:0]       center_position;
		logic [GAIN_W-1:0]      gain_p;
		logic [GAIN_W-1:0]      gain_i;
		logic [GAIN_W-1:0]      gain_d;
		logic [DUTY_W-1:0]      base_left;
		logic [DUTY_W-1:0]      base_right;
		logic [DUTY_W-1:0]      duty_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_0;
		logic [SAMPLE_BITS-1:0] sample_1;
		logic [SAMPLE_BITS-1:0] sample_2;
		logic [SAMPLE_BITS-1:0] sample_3;
		logic [SAMPLE_BITS-1:0] sample_4;
		logic [SAMPLE_BITS-1:0] sample_5;
		logic [SAMPLE_BITS-1:0] sample_6;
	} scan_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] left_speed;
		logic [DUTY_W-1:0] right_speed;
		logic [POS_W-1:0]  line_position;
	} steer_item_t;

	typedef struct packed {
		logic              en;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                    push;
		logic signed [ERR_W-1:0] err;
	} hist_req_t;

	// ceil(2^18 / count): exact floor divide of the position sum
	function automatic logic [RECIP_W-1:0] pos_recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			4'd1:    r = 19'd262144;
			4'd2:    r = 19'd131072;
			4'd3:    r = 19'd87382;
			4'd4:    r = 19'd65536;
			4'd5:    r = 19'd52429;
			4'd6:    r = 19'd43691;
			4'd7:    r = 19'd37450;
			4'd8:    r = 19'd32768;
			4'd9:    r = 19'd29128;
			4'd10:   r = 19'd26215;
			4'd11:   r = 19'd23832;
			4'd12:   r = 19'd21846;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(
		input logic signed [CORR_W-1:0] v,
		input logic [DUTY_W-1:0]        top
	);
		logic signed [CORR_W-1:0] top_s;
		logic [DUTY_W-1:0]        r;
		top_s = $signed({{(CORR_W-DUTY_W){1'b0}}, top});
		if (v < 0)
			r = '0;
		else if (v > top_s)
			r = top;
		else
			r = v[DUTY_W-1:0];
		return r;
	endfunction

endpackage

// ===== design/lps_scan_if.sv =====
interface lps_scan_if import lps_pkg::*; ();
	logic       valid;
	logic       ready;
	scan_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lps_steer_if.sv =====
interface lps_steer_if import lps_pkg::*; ();
	logic        valid;
	logic        ready;
	steer_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/line_position_pid_steer_top.sv =====
// Line-position PID steering: one scan of seven reflectance samples in, one
// pair of motor duties and the measured line position out. From acceptance
// to its result landing in the output register a scan goes through the
// accept state, then nine sequencer steps, seven of which pass through the
// single shared 22x23 multiplier (the divide by the active-sensor count and
// each of the three divides by 100 are reciprocal multiplies on that unit).
// The next scan can be accepted as soon as the result is in the output
// register, and not before. Error history and previous error clear on
// reset.
`include "line_position_pid_steer_top_defines.svh"

module line_position_pid_steer_top import lps_pkg::*; #(
	parameter int INTEGRAL_TAPS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lps_scan_if.sink              scan,
	lps_steer_if.source           steer
);

	localparam int IW = ERR_W + $clog2(INTEGRAL_TAPS);

	cfg_t              cfg_q;
	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;
	hist_req_t         hist_req;
	logic signed [IW-1:0] integ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold  <= 12'd400;
			cfg_q.center_position <= 10'd400;
			cfg_q.gain_p          <= 8'd4;
			cfg_q.gain_i          <= 8'd1;
			cfg_q.gain_d          <= 8'd1;
			cfg_q.base_left       <= 8'd150;
			cfg_q.base_right      <= 8'd150;
			cfg_q.duty_ceiling    <= 8'd255;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_DARK_THRESHOLD:  cfg_q.dark_threshold  <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_CENTER_POSITION: cfg_q.center_position <= cfg_wdata[POS_W-1:0];
				REG_GAIN_P:          cfg_q.gain_p          <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_I:          cfg_q.gain_i          <= cfg_wdata[GAIN_W-1:0];
				REG_GAIN_D:          cfg_q.gain_d          <= cfg_wdata[GAIN_W-1:0];
				REG_BASE_LEFT:       cfg_q.base_left       <= cfg_wdata[DUTY_W-1:0];
				REG_BASE_RIGHT:      cfg_q.base_right      <= cfg_wdata[DUTY_W-1:0];
				REG_DUTY_CEILING:    cfg_q.duty_ceiling    <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	lps_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	lps_hist #(
		.TAPS (INTEGRAL_TAPS),
		.IW   (IW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hist_req),
		.integ  (integ)
	);

	lps_ctrl #(
		.IW (IW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.scan_valid (scan.valid),
		.scan_ready (scan.ready),
		.scan_data  (scan.data),
		.out_valid  (steer.valid),
		.out_ready  (steer.ready),
		.out_data   (steer.data),
		.mul_req    (mul_req),
		.prod       (prod),
		.hist_req   (hist_req),
		.integ      (integ)
	);

	`LPS_ASSERT_NEXT(a_busy_after_accept, scan.valid && scan.ready, !scan.ready, "scan accepted while busy")
	`LPS_ASSERT_NOW(a_duty_clamped, steer.valid, (steer.data.left_speed <= cfg_q.duty_ceiling) && (steer.data.right_speed <= cfg_q.duty_ceiling), "duty above ceiling")
	`LPS_ASSERT_NOW(a_pos_range, steer.valid && (steer.data.line_position != '0), (steer.data.line_position >= POS_W'(POS_STEP)) && (steer.data.line_position <= POS_W'(SENSORS * POS_STEP)), "line position out of sensor span")

endmodule

// ===== design/lps_mul.sv =====
module lps_mul import lps_pkg::*; (
	input  logic              clk,
	input  mul_req_t          req,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	// hold the last product while idle so it can be consumed late
	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
	end

	assign prod = prod_q;

endmodule

// ===== design/lps_hist.sv =====
module lps_hist import lps_pkg::*; #(
	parameter int TAPS = 5,
	parameter int IW   = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hist_req_t            req,
	output logic signed [IW-1:0] integ
);

	logic signed [ERR_W-1:0] taps_q [TAPS];
	logic signed [IW-1:0]    sum_q;

	// running sum: add the newest error, drop the one falling off the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				taps_q[i] <= '0;
			sum_q <= '0;
		end else if (req.push) begin
			taps_q[0] <= req.err;
			for (int i = 1; i < TAPS; i++)
				taps_q[i] <= taps_q[i-1];
			sum_q <= sum_q - IW'(taps_q[TAPS-1]) + IW'(req.err);
		end
	end

	assign integ = sum_q;

endmodule

// ===== design/lps_ctrl.sv =====
module lps_ctrl import lps_pkg::*; #(
	parameter int IW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 scan_valid,
	output logic                 scan_ready,
	input  scan_item_t           scan_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output steer_item_t          out_data,
	output mul_req_t             mul_req,
	input  logic [PROD_W-1:0]    prod,
	output hist_req_t            hist_req,
	input  logic signed [IW-1:0] integ
);

	state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0]   samples [SENSORS];
	logic [CNT_W-1:0]         cnt_c, cnt_q;
	logic [SUM_W-1:0]         sum_c, sum_q;
	logic [SUM_W-1:0]         pos_full;
	logic [POS_W-1:0]         pos_c, pos_q;
	logic signed [ERR_W-1:0]  err_c, err_q, prev_q;
	logic signed [DIFF_W-1:0] diff_c, diff_q;
	logic [ERR_W-1:0]         err_mag;
	logic [IW-1:0]            integ_mag;
	logic [DIFF_W-1:0]        diff_mag;
	logic                     sign_q;
	logic [Q_W-1:0]           quot;
	logic signed [CORR_W-1:0] term, corr_q, corr_c;
	logic signed [CORR_W-1:0] left_sum, right_sum;
	logic                     out_load;
	logic                     out_valid_q;
	steer_item_t              out_q;

	assign samples[0] = scan_data.sample_0;
	assign samples[1] = scan_data.sample_1;
	assign samples[2] = scan_data.sample_2;
	assign samples[3] = scan_data.sample_3;
	assign samples[4] = scan_data.sample_4;
	assign samples[5] = scan_data.sample_5;
	assign samples[6] = scan_data.sample_6;

	always_comb begin
		cnt_c = '0;
		sum_c = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (samples[i] < cfg.dark_threshold) begin
				cnt_c = cnt_c + CNT_W'(1);
				sum_c = sum_c + SUM_W'((i + 1) * POS_STEP);
			end
		end
	end

	always_comb begin
		pos_full = prod[POS_SHIFT +: SUM_W];
		if (pos_full > SUM_W'({POS_W{1'b1}}))
			pos_c = '1;
		else
			pos_c = pos_full[POS_W-1:0];
		err_c  = $signed({1'b0, cfg.center_position}) - $signed({1'b0, pos_c});
		diff_c = DIFF_W'(err_c) - DIFF_W'(prev_q);
	end

	assign err_mag   = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
	assign integ_mag = integ[IW-1] ? IW'(-integ) : IW'(integ);
	assign diff_mag  = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

	// quotient of the last divide step, signed by its operand
	assign quot      = prod[DIV_SHIFT +: Q_W];
	assign term      = sign_q ? -$signed({{(CORR_W-Q_W){1'b0}}, quot})
	                          :  $signed({{(CORR_W-Q_W){1'b0}}, quot});
	assign corr_c    = corr_q + term;
	assign left_sum  = $signed({{(CORR_W-DUTY_W){1'b0}}, cfg.base_left}) + corr_c;
	assign right_sum = $signed({{(CORR_W-DUTY_W){1'b0}}, cfg.base_right}) - corr_c;

	always_comb begin
		state_d      = state_q;
		scan_ready   = 1'b0;
		mul_req      = '0;
		hist_req.push = 1'b0;
		hist_req.err  = err_c;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan_ready = 1'b1;
				if (scan_valid)
					state_d = ST_POS;
			end
			ST_POS: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(sum_q);
				mul_req.b  = MUL_BW'(pos_recip(cnt_q));
				state_d    = ST_ERR;
			end
			ST_ERR: begin
				hist_req.push = 1'b1;
				state_d       = ST_P_MUL;
			end
			ST_P_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(err_mag);
				mul_req.b  = MUL_BW'(cfg.gain_p);
				state_d    = ST_P_DIV;
			end
			ST_I_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(integ_mag);
				mul_req.b  = MUL_BW'(cfg.gain_i);
				state_d    = ST_I_DIV;
			end
			ST_D_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_AW'(diff_mag);
				mul_req.b  = MUL_BW'(cfg.gain_d);
				state_d    = ST_D_DIV;
			end
			ST_P_DIV, ST_I_DIV, ST_D_DIV: begin
				mul_req.en = 1'b1;
				mul_req.a  = prod[MUL_AW-1:0];
				mul_req.b  = DIV100_RECIP;
				case (state_q)
					ST_P_DIV: state_d = ST_I_MUL;
					ST_I_DIV: state_d = ST_D_MUL;
					default:  state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ERR)
				prev_q <= err_c;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (scan_valid) begin
					cnt_q <= cnt_c;
					sum_q <= sum_c;
				end
			end
			ST_ERR: begin
				pos_q  <= pos_c;
				err_q  <= err_c;
				diff_q <= diff_c;
			end
			ST_P_MUL: begin
				sign_q <= err_q[ERR_W-1];
				corr_q <= '0;
			end
			ST_I_MUL: begin
				sign_q <= integ[IW-1];
				corr_q <= corr_c;
			end
			ST_D_MUL: begin
				sign_q <= diff_q[DIFF_W-1];
				corr_q <= corr_c;
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.left_speed    <= clamp_duty(left_sum, cfg.duty_ceiling);
			out_q.right_speed   <= clamp_duty(right_sum, cfg.duty_ceiling);
			out_q.line_position <= pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/steer_checker.sv =====
`timescale 1ns / 100ps

module steer_checker import lps_pkg::*; #(
	parameter int HISTORY_DEPTH = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	lps_scan_if                   scan,
	lps_steer_if                  steer,
	output int                    fails,
	output int                    outstanding
);

	localparam int GAIN_SCALE  = 100;
	localparam int POS_LIMIT   = 1023;

	cfg_t        regs;
	int          err_hist [HISTORY_DEPTH];
	int          last_err;
	int          bad;
	steer_item_t duty_queue [$];

	always @(posedge clk or negedge arst_n) begin : watch
		logic [SAMPLE_BITS-1:0] smp [SENSORS];
		int                     hits, pos_sum, pos, err, integ, corr, v_left, v_right;
		steer_item_t            want, got;
		if (!arst_n) begin
			regs = '{dark_threshold: 400, center_position: 400, gain_p: 4, gain_i: 1,
				gain_d: 1, base_left: 150, base_right: 150, duty_ceiling: 255};
			foreach (err_hist[k])
				err_hist[k] = 0;
			last_err = 0;
			bad = 0;
			duty_queue.delete();
			fails <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_DARK_THRESHOLD:  regs.dark_threshold  = cfg_wdata;
					REG_CENTER_POSITION: regs.center_position = cfg_wdata[POS_W-1:0];
					REG_GAIN_P:          regs.gain_p          = cfg_wdata[GAIN_W-1:0];
					REG_GAIN_I:          regs.gain_i          = cfg_wdata[GAIN_W-1:0];
					REG_GAIN_D:          regs.gain_d          = cfg_wdata[GAIN_W-1:0];
					REG_BASE_LEFT:       regs.base_left       = cfg_wdata[DUTY_W-1:0];
					REG_BASE_RIGHT:      regs.base_right      = cfg_wdata[DUTY_W-1:0];
					REG_DUTY_CEILING:    regs.duty_ceiling    = cfg_wdata[DUTY_W-1:0];
					default: ;
				endcase
			end

			if (scan.valid && scan.ready) begin
				smp = '{scan.data.sample_0, scan.data.sample_1, scan.data.sample_2,
					scan.data.sample_3, scan.data.sample_4, scan.data.sample_5,
					scan.data.sample_6};
				hits = 0;
				pos_sum = 0;
				for (int k = 0; k < SENSORS; k++) begin
					if (smp[k] < regs.dark_threshold) begin
						hits++;
						pos_sum += (k + 1) * POS_STEP;
					end
				end
				pos = (hits != 0) ? pos_sum / hits : 0;
				if (pos > POS_LIMIT)
					pos = POS_LIMIT;
				err = int'(regs.center_position) - pos;

				// shift the newest error in, then integrate over the window
				for (int k = HISTORY_DEPTH - 1; k > 0; k--)
					err_hist[k] = err_hist[k - 1];
				err_hist[0] = err;
				integ = 0;
				for (int k = 0; k < HISTORY_DEPTH; k++)
					integ += err_hist[k];

				// each term truncates toward zero on its own
				corr = (err * int'(regs.gain_p)) / GAIN_SCALE
					+ (integ * int'(regs.gain_i)) / GAIN_SCALE
					+ ((err - last_err) * int'(regs.gain_d)) / GAIN_SCALE;
				last_err = err;

				v_left  = int'(regs.base_left) + corr;
				v_right = int'(regs.base_right) - corr;
				want.left_speed  = (v_left < 0) ? '0 :
					(v_left > int'(regs.duty_ceiling)) ? regs.duty_ceiling : v_left[DUTY_W-1:0];
				want.right_speed = (v_right < 0) ? '0 :
					(v_right > int'(regs.duty_ceiling)) ? regs.duty_ceiling
						: v_right[DUTY_W-1:0];
				want.line_position = pos[POS_W-1:0];
				duty_queue.push_back(want);
			end

			if (steer.valid && steer.ready) begin
				got = steer.data;
				if (duty_queue.size() == 0) begin
					bad++;
					$display("%0t: unexpected steer beat: left %0d right %0d position %0d",
						$time, got.left_speed, got.right_speed, got.line_position);
				end else begin
					want = duty_queue.pop_front();
					if (got.left_speed !== want.left_speed
						|| got.right_speed !== want.right_speed
						|| got.line_position !== want.line_position) begin
						bad++;
						$display({"%0t: steer mismatch: expected left %0d right %0d ",
							"position %0d, got left %0d right %0d position %0d"},
							$time, want.left_speed, want.right_speed, want.line_position,
							got.left_speed, got.right_speed, got.line_position);
					end
				end
			end

			fails <= bad;
			outstanding <= duty_queue.size();
		end
	end

endmodule

// ===== tb/line_position_pid_steer_top_test.sv =====
`timescale 1ns / 100ps

module line_position_pid_steer_top_test;
	import lps_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_SCANS   = 103;
	localparam int IDLE_PCT      = 26;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fails;
	int                    outstanding;
	int                    cycles = 0;
	bit                    calm;
	logic [SAMPLE_BITS-1:0] thr_now;

	lps_scan_if  scan();
	lps_steer_if steer();

	line_position_pid_steer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.scan      (scan),
		.steer     (steer)
	);

	steer_checker #(.HISTORY_DEPTH(5)) u_steer_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.scan        (scan),
		.steer       (steer),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		steer.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sensor k is dark (on the line) where mask bit k is set
	function automatic scan_item_t mask_scan(logic [SENSORS-1:0] mask,
		logic [SAMPLE_BITS-1:0] dark_v, logic [SAMPLE_BITS-1:0] light_v);
		logic [SAMPLE_BITS-1:0] smp [SENSORS];
		for (int k = 0; k < SENSORS; k++)
			smp[k] = mask[k] ? dark_v : light_v;
		return '{smp[0], smp[1], smp[2], smp[3], smp[4], smp[5], smp[6]};
	endfunction

	// mostly a contiguous line under one to three sensors, some scattered
	// patterns, some lost-line scans and some raw noise
	function automatic scan_item_t random_scan(logic [SAMPLE_BITS-1:0] thr);
		logic [SAMPLE_BITS-1:0] smp [SENSORS];
		bit                     dark;
		int                     kind, first, span;
		kind  = $urandom_range(99);
		first = $urandom_range(SENSORS - 1);
		span  = $urandom_range(3, 1);
		for (int k = 0; k < SENSORS; k++) begin
			if (kind < 60)
				dark = (k >= first) && (k < first + span);
			else if (kind < 80)
				dark = ($urandom_range(1) != 0);
			else
				dark = 1'b0;
			if (kind >= 90)
				smp[k] = SAMPLE_BITS'($urandom_range(4095));
			else if (dark && thr != 0)
				smp[k] = ($urandom_range(9) == 0) ? SAMPLE_BITS'(thr - 1)
					: SAMPLE_BITS'($urandom_range(thr - 1));
			else
				smp[k] = ($urandom_range(9) == 0) ? thr
					: SAMPLE_BITS'($urandom_range(4095, thr));
		end
		return '{smp[0], smp[1], smp[2], smp[3], smp[4], smp[5], smp[6]};
	endfunction

	task automatic write_reg(reg_idx_t idx, int val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		if (idx == REG_DARK_THRESHOLD)
			thr_now = val[SAMPLE_BITS-1:0];
		@(posedge clk);
	endtask

	// junk sets the data bits above each register's width
	task automatic set_config(int thr, int center, int gp, int gi, int gd,
		int bl, int br, int top, bit junk);
		write_reg(REG_DARK_THRESHOLD, thr);
		write_reg(REG_CENTER_POSITION, center | (junk ? $urandom_range(3) << POS_W : 0));
		write_reg(REG_GAIN_P, gp | (junk ? $urandom_range(15) << GAIN_W : 0));
		write_reg(REG_GAIN_I, gi | (junk ? $urandom_range(15) << GAIN_W : 0));
		write_reg(REG_GAIN_D, gd | (junk ? $urandom_range(15) << GAIN_W : 0));
		write_reg(REG_BASE_LEFT, bl | (junk ? $urandom_range(15) << DUTY_W : 0));
		write_reg(REG_BASE_RIGHT, br | (junk ? $urandom_range(15) << DUTY_W : 0));
		write_reg(REG_DUTY_CEILING, top | (junk ? $urandom_range(15) << DUTY_W : 0));
		cfg_we <= 1'b0;
	endtask

	task automatic send_scan(scan_item_t item);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			scan.valid <= 1'b0;
			@(posedge clk);
		end
		scan.valid <= 1'b1;
		scan.data  <= item;
		do
			@(posedge clk);
		while (!scan.ready);
	endtask

	// drop valid, wait out every pending result, then let the block settle
	task automatic drain();
		scan.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		scan_item_t directed [$];
		bit         big;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_DARK_THRESHOLD;
		cfg_wdata   = '0;
		scan.valid  = 1'b0;
		scan.data   = '0;
		calm        = 1'b0;
		thr_now     = 400;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: lost line, full line, each sensor alone at the threshold edge
		directed.push_back(mask_scan('0, 0, 4095));
		directed.push_back(mask_scan('1, 0, 4095));
		for (int k = 0; k < SENSORS; k++)
			directed.push_back(mask_scan(SENSORS'(1 << k), 399, 400));
		directed.push_back(mask_scan(7'b0000011, 0, 4095));
		directed.push_back(mask_scan(7'b0000111, 0, 4095));
		directed.push_back(mask_scan(7'b1000001, 0, 4095));
		directed.push_back(mask_scan(7'b0001011, 0, 4095));
		directed.push_back(mask_scan('0, 12'haaa, 12'haaa));
		directed.push_back(mask_scan('0, 12'h555, 12'h555));
		foreach (directed[k])
			send_scan(directed[k]);
		drain();

		// top threshold, far center, full gains: left saturates high, right low
		set_config(4095, 1023, 255, 255, 255, 255, 0, 255, 1'b0);
		send_scan(mask_scan('0, 0, 4095));
		send_scan(mask_scan('1, 4094, 4095));
		send_scan(mask_scan(7'b1000000, 0, 4095));
		send_scan(mask_scan(7'b0000001, 0, 4095));
		drain();

		// zero ceiling: both duties pinned at zero
		set_config(4095, 0, 255, 255, 255, 0, 255, 0, 1'b0);
		send_scan(mask_scan('1, 0, 4095));
		send_scan(mask_scan(7'b1000000, 0, 4095));
		send_scan(mask_scan('0, 0, 4095));
		drain();

		// zero threshold: no sensor can be dark, zero gains
		set_config(0, 700, 0, 0, 0, 200, 10, 128, 1'b0);
		send_scan(mask_scan('0, 0, 0));
		send_scan(mask_scan('0, 4095, 4095));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			calm = (p == 4);
			big  = (p % 3 == 2);
			set_config($urandom_range(3500, 200),
				($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(700),
				big ? $urandom_range(255) : $urandom_range(60),
				big ? $urandom_range(255) : $urandom_range(20),
				big ? $urandom_range(255) : $urandom_range(60),
				$urandom_range(255), $urandom_range(255),
				($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(255, 100),
				p % 2);
			repeat (PHASE_SCANS)
				send_scan(random_scan(thr_now));
			drain();
		end

		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
